// File: rtl/core/fpvc_pkg.sv
// ----------------------------------------------------------------------------
// fpvc_pkg
// Shared types and constants of the front panel power and volume controller.
// ----------------------------------------------------------------------------
package fpvc_pkg;

    // Counter width default for the timer registers
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register geometry
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_POWERDOWN  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHUT_BLINK = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PANIC_BLINK = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT     = 3'd4;

    // Configuration reset values
    localparam logic [CFG_WIDTH-1:0] RST_POWERDOWN   = 16'd12000;
    localparam logic [CFG_WIDTH-1:0] RST_SHUT_BLINK  = 16'd25;
    localparam logic [CFG_WIDTH-1:0] RST_PANIC_BLINK = 16'd12;
    localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE    = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RST_REPEAT      = 16'd1;

    // Item kinds
    localparam logic [1:0] MODE_PANEL  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_PANIC  = 2'd2;
    localparam logic [1:0] MODE_VOLUME = 2'd3;

    // Active-low button bit positions in the panel byte
    localparam int BTN_POWER = 1;
    localparam int BTN_DOWN  = 4;
    localparam int BTN_UP    = 6;

    // Auto-repeat direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Volume limits
    localparam logic [7:0] VOL_MAX = 8'hff;
    localparam logic [7:0] VOL_MIN = 8'h00;

    // Configuration register bank
    typedef struct packed {
        logic [CFG_WIDTH-1:0] powerdown_ticks;
        logic [CFG_WIDTH-1:0] shutdown_blink_ticks;
        logic [CFG_WIDTH-1:0] panic_blink_ticks;
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] repeat_ticks;
    } t_cfg;

    // One input item
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] panel_buttons;
        logic       irq_held;
        logic       init_present;
        logic [7:0] volume_value;
    } t_item;

    // One result item
    typedef struct packed {
        logic [7:0] volume;
        logic       leds_off;
        logic       shutting_down;
        logic       panicked;
        logic       power_off;
        logic       reboot;
        logic       panel_irq_enabled;
    } t_result;

endpackage

// File: rtl/core/fpvc_cfg.sv
// ----------------------------------------------------------------------------
// fpvc_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module fpvc_cfg
    import fpvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    // Load reset values, then take writes by index; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.powerdown_ticks      <= RST_POWERDOWN;
            r_cfg.shutdown_blink_ticks <= RST_SHUT_BLINK;
            r_cfg.panic_blink_ticks    <= RST_PANIC_BLINK;
            r_cfg.debounce_ticks       <= RST_DEBOUNCE;
            r_cfg.repeat_ticks         <= RST_REPEAT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POWERDOWN:   r_cfg.powerdown_ticks      <= i_cfg_data;
                REG_SHUT_BLINK:  r_cfg.shutdown_blink_ticks <= i_cfg_data;
                REG_PANIC_BLINK: r_cfg.panic_blink_ticks    <= i_cfg_data;
                REG_DEBOUNCE:    r_cfg.debounce_ticks       <= i_cfg_data;
                REG_REPEAT:      r_cfg.repeat_ticks         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/fpvc_core.sv
// ----------------------------------------------------------------------------
// fpvc_core
// Controller state and its single-pass update for one item.
// ----------------------------------------------------------------------------
module fpvc_core
    import fpvc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [32:0] COUNT_MAX_W = (33'd1 << CW) - 33'd1;
    localparam logic [31:0] COUNT_MAX   = COUNT_MAX_W[31:0];

    // Clamp a register value into a timer load: zero loads one, saturate at the top
    function automatic logic [CW-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > COUNT_MAX) begin
            w = COUNT_MAX;
        end
        return w[CW-1:0];
    endfunction

    logic [7:0]    r_volume, n_volume;
    logic          r_shutdown, n_shutdown;
    logic          r_panic, n_panic;
    logic          r_led_off, n_led_off;
    logic          r_blink_act, n_blink_act;
    logic [CW-1:0] r_blink_per, n_blink_per;
    logic [CW-1:0] r_blink_cnt, n_blink_cnt;
    logic          r_pwr_armed, n_pwr_armed;
    logic [CW-1:0] r_pwr_cnt, n_pwr_cnt;
    logic          r_deb_act, n_deb_act;
    logic [CW-1:0] r_deb_cnt, n_deb_cnt;
    logic [1:0]    r_rep_dir, n_rep_dir;
    logic [CW-1:0] r_rep_cnt, n_rep_cnt;
    logic          r_off, n_off;
    logic          r_reboot, n_reboot;

    logic [CW-1:0] dec_pwr, dec_blink, dec_deb, dec_rep;
    logic          stop;

    assign dec_pwr   = r_pwr_cnt - CW'(1);
    assign dec_blink = r_blink_cnt - CW'(1);
    assign dec_deb   = r_deb_cnt - CW'(1);
    assign dec_rep   = r_rep_cnt - CW'(1);

    // Next state for one item; stop ends a tick early like a fired terminal timer
    always_comb begin
        n_volume    = r_volume;
        n_shutdown  = r_shutdown;
        n_panic     = r_panic;
        n_led_off   = r_led_off;
        n_blink_act = r_blink_act;
        n_blink_per = r_blink_per;
        n_blink_cnt = r_blink_cnt;
        n_pwr_armed = r_pwr_armed;
        n_pwr_cnt   = r_pwr_cnt;
        n_deb_act   = r_deb_act;
        n_deb_cnt   = r_deb_cnt;
        n_rep_dir   = r_rep_dir;
        n_rep_cnt   = r_rep_cnt;
        n_off       = r_off;
        n_reboot    = r_reboot;
        stop        = 1'b0;

        if (!r_off && !r_reboot) begin
            case (i_item.mode)
                MODE_PANEL: begin
                    if (!r_deb_act) begin
                        // Mask further panel events while the line is held
                        if (i_item.irq_held) begin
                            n_deb_act = 1'b1;
                            n_deb_cnt = load_count(i_cfg.debounce_ticks);
                        end
                        // Power press: ignored after panic
                        if (!i_item.panel_buttons[BTN_POWER] && !r_panic) begin
                            if (r_shutdown || !i_item.init_present) begin
                                n_off = 1'b1;
                            end else begin
                                n_shutdown  = 1'b1;
                                n_blink_per = load_count(i_cfg.shutdown_blink_ticks);
                                n_led_off   = !r_led_off;
                                n_blink_act = 1'b1;
                                n_blink_cnt = n_blink_per;
                                n_pwr_armed = 1'b1;
                                n_pwr_cnt   = load_count(i_cfg.powerdown_ticks);
                            end
                        end
                        // Volume presses; down wins over up
                        if (!n_off) begin
                            if (!i_item.panel_buttons[BTN_UP]) begin
                                n_rep_dir = DIR_UP;
                                n_rep_cnt = load_count(i_cfg.repeat_ticks);
                            end
                            if (!i_item.panel_buttons[BTN_DOWN]) begin
                                n_rep_dir = DIR_DOWN;
                                n_rep_cnt = load_count(i_cfg.repeat_ticks);
                            end
                        end
                    end
                end
                MODE_TICK: begin
                    // Power-off countdown
                    if (r_pwr_armed) begin
                        n_pwr_cnt = dec_pwr;
                        if (dec_pwr == '0) begin
                            n_pwr_armed = 1'b0;
                            n_off       = 1'b1;
                            stop        = 1'b1;
                        end
                    end
                    // LED blink
                    if (!stop && r_blink_act) begin
                        n_blink_cnt = dec_blink;
                        if (dec_blink == '0) begin
                            n_led_off   = !r_led_off;
                            n_blink_cnt = r_blink_per;
                        end
                    end
                    // Debounce recheck
                    if (!stop && r_deb_act) begin
                        n_deb_cnt = dec_deb;
                        if (dec_deb == '0) begin
                            if (i_item.irq_held) begin
                                n_deb_cnt = load_count(i_cfg.debounce_ticks);
                            end else if (r_panic) begin
                                n_reboot = 1'b1;
                                stop     = 1'b1;
                            end else begin
                                n_deb_act = 1'b0;
                            end
                        end
                    end
                    // Volume step and auto-repeat
                    if (!stop && (r_rep_dir == DIR_UP || r_rep_dir == DIR_DOWN)) begin
                        n_rep_cnt = dec_rep;
                        if (dec_rep == '0) begin
                            if (r_rep_dir == DIR_UP) begin
                                if (r_volume != VOL_MAX) begin
                                    n_volume = r_volume + 8'd1;
                                end
                            end else if (r_volume != VOL_MIN) begin
                                n_volume = r_volume - 8'd1;
                            end
                            if (i_item.irq_held) begin
                                n_rep_cnt = load_count(i_cfg.repeat_ticks);
                            end else begin
                                n_rep_dir = DIR_NONE;
                            end
                        end
                    end
                end
                MODE_PANIC: begin
                    // First panic only: fast blink
                    if (!r_panic) begin
                        n_panic     = 1'b1;
                        n_blink_per = load_count(i_cfg.panic_blink_ticks);
                        n_led_off   = !r_led_off;
                        n_blink_act = 1'b1;
                        n_blink_cnt = n_blink_per;
                    end
                end
                default: begin
                    n_volume = i_item.volume_value;
                end
            endcase
        end
    end

    // Commit the state on each transfer into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= '0;
            r_shutdown  <= 1'b0;
            r_panic     <= 1'b0;
            r_led_off   <= 1'b0;
            r_blink_act <= 1'b0;
            r_blink_per <= '0;
            r_blink_cnt <= '0;
            r_pwr_armed <= 1'b0;
            r_pwr_cnt   <= '0;
            r_deb_act   <= 1'b0;
            r_deb_cnt   <= '0;
            r_rep_dir   <= DIR_NONE;
            r_rep_cnt   <= '0;
            r_off       <= 1'b0;
            r_reboot    <= 1'b0;
        end else if (i_adv) begin
            r_volume    <= n_volume;
            r_shutdown  <= n_shutdown;
            r_panic     <= n_panic;
            r_led_off   <= n_led_off;
            r_blink_act <= n_blink_act;
            r_blink_per <= n_blink_per;
            r_blink_cnt <= n_blink_cnt;
            r_pwr_armed <= n_pwr_armed;
            r_pwr_cnt   <= n_pwr_cnt;
            r_deb_act   <= n_deb_act;
            r_deb_cnt   <= n_deb_cnt;
            r_rep_dir   <= n_rep_dir;
            r_rep_cnt   <= n_rep_cnt;
            r_off       <= n_off;
            r_reboot    <= n_reboot;
        end
    end

    // Result shows the state after the item
    assign o_result.volume            = n_volume;
    assign o_result.leds_off          = n_led_off;
    assign o_result.shutting_down     = n_shutdown;
    assign o_result.panicked          = n_panic;
    assign o_result.power_off         = n_off;
    assign o_result.reboot            = n_reboot;
    assign o_result.panel_irq_enabled = !n_deb_act;

endmodule

// File: rtl/core/front_panel_power_volume_controller.sv
// ----------------------------------------------------------------------------
// front_panel_power_volume_controller
// Front panel power, shutdown blink, panic and volume controller.
//
//   channel  direction  handshake           payload
//   s_       in         s_tvalid/s_tready   s_tuser mode, s_tdata item fields
//   m_       out        m_tvalid/m_tready   m_tdata result fields
//   cfg      in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the input register, then the state update into the result register,
// before its result can leave.
// The state update is one combinational pass over a handful of counters.
// Reset is synchronous and active low; it loads the register defaults and
// clears the controller state and the valid flags. A stalled output holds its result and the input register
// still fills, so one further item waits until the output drains.
// ----------------------------------------------------------------------------
module front_panel_power_volume_controller
    import fpvc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [7:0] panel_buttons, [8] irq_held, [9] init_present, [17:10] volume_value
    input  logic [23:0]              s_tdata,
    // [1:0] mode
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [7:0] volume, [8] leds_off, [9] shutting_down, [10] panicked,
    // [11] power_off, [12] reboot, [13] panel_irq_enabled
    output logic [15:0]              m_tdata,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out;
    t_result result;
    logic    r_out_valid;
    logic    adv;

    // Move the held item into the result stage when the output has room
    assign adv      = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || adv;

    fpvc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fpvc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_item.mode          <= s_tuser;
            r_in_item.panel_buttons <= s_tdata[7:0];
            r_in_item.irq_held      <= s_tdata[8];
            r_in_item.init_present  <= s_tdata[9];
            r_in_item.volume_value  <= s_tdata[17:10];
        end
    end

    // Result register valid: set on advance, drop on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out.panel_irq_enabled, r_out.reboot, r_out.power_off,
                       r_out.panicked, r_out.shutting_down, r_out.leds_off, r_out.volume};

endmodule

// File: bench/fpvc_checker.sv
// ----------------------------------------------------------------------------
// fpvc_checker
// Watches the item, result and register write channels of the front panel
// controller. It keeps its own copy of the controller state, works out the
// status that each accepted item must produce, and compares each result
// transfer field by field with the oldest status still owed.
// ----------------------------------------------------------------------------
module fpvc_checker
    import fpvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // [7:0] panel_buttons, [8] irq_held, [9] init_present, [17:10] volume_value
    input  logic [23:0]              s_tdata,
    // [1:0] mode
    input  logic [1:0]               s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // [7:0] volume, [8] leds_off, [9] shutting_down, [10] panicked,
    // [11] power_off, [12] reboot, [13] panel_irq_enabled
    input  logic [15:0]              m_tdata,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 30;

    // Register copy and controller state
    t_cfg        regs;
    logic [7:0]  level;
    logic        shut_on;
    logic        panic_on;
    logic        leds_dark;
    logic        blink_on;
    logic [15:0] blink_len;
    logic [15:0] blink_left;
    logic        off_armed;
    logic [15:0] off_left;
    logic        mask_on;
    logic [15:0] mask_left;
    logic [1:0]  step_dir;
    logic [15:0] step_left;
    logic        off_req;
    logic        reboot_req;

    // Status snapshots owed by the block, oldest first
    t_result     status_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_errors < MAX_PRINTS)
            $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // A zero period counts as one tick
    function automatic logic [15:0] period_of(input logic [15:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    function automatic void restart_blink(input logic [15:0] period);
        blink_len  = period_of(period);
        leds_dark  = !leds_dark;
        blink_on   = 1'b1;
        blink_left = blink_len;
    endfunction

    function automatic void reset_state();
        regs.powerdown_ticks      = RST_POWERDOWN;
        regs.shutdown_blink_ticks = RST_SHUT_BLINK;
        regs.panic_blink_ticks    = RST_PANIC_BLINK;
        regs.debounce_ticks       = RST_DEBOUNCE;
        regs.repeat_ticks         = RST_REPEAT;
        level      = VOL_MIN;
        shut_on    = 1'b0;
        panic_on   = 1'b0;
        leds_dark  = 1'b0;
        blink_on   = 1'b0;
        blink_len  = '0;
        blink_left = '0;
        off_armed  = 1'b0;
        off_left   = '0;
        mask_on    = 1'b0;
        mask_left  = '0;
        step_dir   = DIR_NONE;
        step_left  = '0;
        off_req    = 1'b0;
        reboot_req = 1'b0;
    endfunction

    // Power button: ignored after panic, second press or no init cuts power
    function automatic void press_power(input logic init_ok);
        if (panic_on)
            return;
        if (shut_on || !init_ok) begin
            off_req = 1'b1;
            return;
        end
        shut_on = 1'b1;
        restart_blink(regs.shutdown_blink_ticks);
        off_armed = 1'b1;
        off_left  = period_of(regs.powerdown_ticks);
    endfunction

    function automatic void take_panel(input t_item it);
        if (mask_on)
            return;
        if (it.irq_held) begin
            mask_on   = 1'b1;
            mask_left = period_of(regs.debounce_ticks);
        end
        if (!it.panel_buttons[BTN_POWER]) begin
            press_power(it.init_present);
            if (off_req)
                return;
        end
        if (!it.panel_buttons[BTN_UP]) begin
            step_dir  = DIR_UP;
            step_left = period_of(regs.repeat_ticks);
        end
        // down is served last so it wins over up
        if (!it.panel_buttons[BTN_DOWN]) begin
            step_dir  = DIR_DOWN;
            step_left = period_of(regs.repeat_ticks);
        end
    endfunction

    // Serve the timers in order: power, blink, debounce, volume repeat
    function automatic void take_tick(input logic held);
        if (off_armed) begin
            off_left = off_left - 16'd1;
            if (off_left == '0) begin
                off_armed = 1'b0;
                off_req   = 1'b1;
                return;
            end
        end
        if (blink_on) begin
            blink_left = blink_left - 16'd1;
            if (blink_left == '0) begin
                leds_dark  = !leds_dark;
                blink_left = blink_len;
            end
        end
        if (mask_on) begin
            mask_left = mask_left - 16'd1;
            if (mask_left == '0) begin
                if (held) begin
                    mask_left = period_of(regs.debounce_ticks);
                end else if (panic_on) begin
                    reboot_req = 1'b1;
                    return;
                end else begin
                    mask_on = 1'b0;
                end
            end
        end
        if (step_dir == DIR_UP || step_dir == DIR_DOWN) begin
            step_left = step_left - 16'd1;
            if (step_left == '0) begin
                if (step_dir == DIR_UP) begin
                    if (level != VOL_MAX)
                        level = level + 8'd1;
                end else if (level != VOL_MIN) begin
                    level = level - 8'd1;
                end
                if (held)
                    step_left = period_of(regs.repeat_ticks);
                else
                    step_dir = DIR_NONE;
            end
        end
    endfunction

    // Advance the controller by one item and return the status it shows
    function automatic t_result step_controller(input t_item it);
        t_result r;
        if (!off_req && !reboot_req) begin
            case (it.mode)
                MODE_PANEL: take_panel(it);
                MODE_TICK:  take_tick(it.irq_held);
                MODE_PANIC: begin
                    if (!panic_on) begin
                        panic_on = 1'b1;
                        restart_blink(regs.panic_blink_ticks);
                    end
                end
                default:    level = it.volume_value;
            endcase
        end
        r.volume            = level;
        r.leds_off          = leds_dark;
        r.shutting_down     = shut_on;
        r.panicked          = panic_on;
        r.power_off         = off_req;
        r.reboot            = reboot_req;
        r.panel_irq_enabled = !mask_on;
        return r;
    endfunction

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch(name, got, want);
    endtask

    task automatic check_status(input logic [15:0] data);
        t_result want;
        if (status_q.size() == 0) begin
            report_mismatch("result with nothing pending", int'(data), 0);
            return;
        end
        want = status_q.pop_front();
        compare_field("volume", int'(data[7:0]), int'(want.volume));
        compare_field("leds_off", int'(data[8]), int'(want.leds_off));
        compare_field("shutting_down", int'(data[9]), int'(want.shutting_down));
        compare_field("panicked", int'(data[10]), int'(want.panicked));
        compare_field("power_off", int'(data[11]), int'(want.power_off));
        compare_field("reboot", int'(data[12]), int'(want.reboot));
        compare_field("panel_irq_enabled", int'(data[13]), int'(want.panel_irq_enabled));
        o_checked++;
    endtask

    // Track writes, accepted items and result transfers at each edge
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            reset_state();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POWERDOWN:   regs.powerdown_ticks      = i_cfg_data;
                    REG_SHUT_BLINK:  regs.shutdown_blink_ticks = i_cfg_data;
                    REG_PANIC_BLINK: regs.panic_blink_ticks    = i_cfg_data;
                    REG_DEBOUNCE:    regs.debounce_ticks       = i_cfg_data;
                    REG_REPEAT:      regs.repeat_ticks         = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_status(m_tdata);
            if (s_tvalid && s_tready) begin
                it.mode          = s_tuser;
                it.panel_buttons = s_tdata[7:0];
                it.irq_held      = s_tdata[8];
                it.init_present  = s_tdata[9];
                it.volume_value  = s_tdata[17:10];
                status_q.push_back(step_controller(it));
            end
        end
        o_pending = status_q.size();
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the front panel power and volume controller. A short directed
// run covers volume saturation, debounce masking and button priority; random
// press sequences then run under several register settings, and the run ends
// in one of the shutdown, power-off or panic and reboot paths, followed by
// items that must leave the latched state alone. Sender bursts, receiver
// stalls and one long receiver hold-off vary the flow; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import fpvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] BTN_NONE   = 8'hff;
    localparam int         LONG_HOLD  = 80;
    localparam int         SETTLE     = 4;
    localparam int         RANDOM_SET = 280;
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE = REG_REPEAT + 3'd1;

    typedef enum int {
        END_SECOND_PRESS,
        END_COUNTDOWN,
        END_PANIC,
        END_NO_INIT
    } t_ending;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     s_tvalid   = 1'b0;
    logic                     s_tready;
    // [7:0] panel_buttons, [8] irq_held, [9] init_present, [17:10] volume_value
    logic [23:0]              s_tdata    = '0;
    // [1:0] mode
    logic [1:0]               s_tuser    = MODE_TICK;
    logic                     m_tvalid;
    logic                     m_tready   = 1'b0;
    // [7:0] volume, [8] leds_off, [9] shutting_down, [10] panicked,
    // [11] power_off, [12] reboot, [13] panel_irq_enabled
    logic [15:0]              m_tdata;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx  = REG_POWERDOWN;
    logic [CFG_WIDTH-1:0]     i_cfg_data = '0;

    int      errors;
    int      pending;
    int      checked;
    int      items_sent = 0;
    int      kind_count[4] = '{0, 0, 0, 0};
    int      settings_used = 0;
    int      burst_left = 1;
    int      hold_requests = 0;
    int      hold_served = 0;
    t_ending ending;

    front_panel_power_volume_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fpvc_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the run hangs
    initial begin
        #5ms;
        $display("Timeout: run did not finish, %0d results still owed", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: stall in stretches of varying style, with long hold-offs on request
    initial begin : receiver
        int style;
        int stretch;
        int beat;
        beat = 0;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(negedge i_clk);
                if (hold_served != hold_requests) begin
                    hold_served++;
                    m_tready = 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                end
                beat++;
                case (style)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ($urandom_range(0, 2) == 0);
                    default: m_tready = ((beat % 4) != 3);
                endcase
            end
        end
    end

    // Offer one item and hold it until the transfer; pause between bursts
    task automatic send_fields(input logic [1:0] mode, input logic [7:0] buttons,
                               input logic held, input logic init_ok,
                               input logic [7:0] vol);
        int gap;
        s_tuser  = mode;
        s_tdata  = {6'd0, vol, init_ok, held, buttons};
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        kind_count[mode]++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic send_tick(input logic held);
        send_fields(MODE_TICK, 8'($urandom_range(0, 255)), held, 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
    endtask

    task automatic send_panel(input logic [7:0] buttons, input logic held, input logic init_ok);
        send_fields(MODE_PANEL, buttons, held, init_ok, 8'($urandom_range(0, 255)));
    endtask

    // Stop offering and wait until every owed result has come out
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic write_all(input logic [15:0] pd, input logic [15:0] sb,
                             input logic [15:0] pb, input logic [15:0] deb,
                             input logic [15:0] rep);
        write_reg(REG_POWERDOWN, pd);
        write_reg(REG_SHUT_BLINK, sb);
        write_reg(REG_PANIC_BLINK, pb);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_REPEAT, rep);
        settings_used++;
    endtask

    // Button byte with a typical press; power stays released unless allowed
    function automatic logic [7:0] press_pattern(input bit power_ok);
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:       b = BTN_NONE & ~(8'd1 << BTN_UP);
            1:       b = BTN_NONE & ~(8'd1 << BTN_DOWN);
            2:       b = BTN_NONE & ~((8'd1 << BTN_UP) | (8'd1 << BTN_DOWN));
            3:       b = BTN_NONE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        b[BTN_POWER] = !(power_ok && $urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic logic [7:0] host_volume();
        case ($urandom_range(0, 5))
            0:       return VOL_MIN;
            1:       return VOL_MAX;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly press, hold and release sequences, with host writes and stray items
    task automatic random_mix(input int quota, input bit power_ok, input bit panic_ok);
        int         stop_at;
        int         r;
        int         k;
        logic [1:0] mode;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_panel(press_pattern(power_ok), $urandom_range(0, 3) != 0,
                           1'($urandom_range(0, 1)));
                k = $urandom_range(0, 10);
                repeat (k) begin
                    if ($urandom_range(0, 7) == 0)
                        send_panel(press_pattern(power_ok), 1'b1, 1'($urandom_range(0, 1)));
                    else
                        send_tick(1'b1);
                end
                k = $urandom_range(1, 8);
                repeat (k) send_tick(1'b0);
            end else if (r < 82) begin
                send_fields(MODE_VOLUME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), host_volume());
            end else if (r < 86 && panic_ok) begin
                send_fields(MODE_PANIC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                mode = 2'($urandom_range(0, 3));
                if (mode == MODE_PANIC && !panic_ok)
                    mode = MODE_TICK;
                send_fields(mode,
                            press_pattern(power_ok) & (8'($urandom_range(0, 255)) | 8'h02),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] pwr_press;
        pwr_press = BTN_NONE & ~(8'd1 << BTN_POWER);

        // Synchronous reset, released at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed: saturation, masking, priority, unused fields, default registers
        send_tick(1'b1);
        send_fields(MODE_VOLUME, 8'h00, 1'b0, 1'b0, VOL_MAX);
        send_panel(BTN_NONE & ~(8'd1 << BTN_UP), 1'b0, 1'b0);
        send_tick(1'b0);
        send_fields(MODE_VOLUME, 8'hff, 1'b1, 1'b1, VOL_MIN);
        send_panel(BTN_NONE & ~(8'd1 << BTN_DOWN), 1'b1, 1'b1);
        send_panel(BTN_NONE & ~(8'd1 << BTN_UP), 1'b1, 1'b0);
        repeat (5) send_tick(1'b1);
        send_fields(MODE_VOLUME, 8'h5a, 1'b0, 1'b1, 8'h80);
        repeat (5) send_tick(1'b0);
        send_panel(BTN_NONE & ~((8'd1 << BTN_UP) | (8'd1 << BTN_DOWN)), 1'b0, 1'b1);
        send_tick(1'b0);
        send_panel(BTN_NONE, 1'b1, 1'b0);
        repeat (5) send_tick(1'b0);
        drain_results();

        // Random sequences under several register settings, no power or panic yet
        write_all('0, '0, '0, '0, '0);
        random_mix(RANDOM_SET, 1'b0, 1'b0);
        drain_results();

        write_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 4)));
        random_mix(40, 1'b0, 1'b0);
        hold_requests++;
        random_mix(RANDOM_SET - 40, 1'b0, 1'b0);
        drain_results();

        write_reg(IDX_SPARE + 3'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
        write_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)), 16'd1, 16'hffff);
        random_mix(RANDOM_SET, 1'b0, 1'b0);
        drain_results();

        write_all(16'd1, 16'hffff, 16'hffff, 16'($urandom_range(2, 12)),
                  16'($urandom_range(1, 6)));
        random_mix(RANDOM_SET, 1'b0, 1'b0);
        drain_results();

        // Endgame: a power press that starts shutdown or, without init, cuts power; then a latching path
        ending = t_ending'($urandom_range(0, 3));
        write_all((ending == END_COUNTDOWN) ? (($urandom_range(0, 3) == 0) ? 16'd1
                                                : 16'($urandom_range(2, 150)))
                                            : 16'hffff,
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
        if (ending == END_NO_INIT) begin
            send_panel(pwr_press, 1'($urandom_range(0, 1)), 1'b0);
            random_mix(150, 1'b1, 1'b1);
        end else begin
            send_panel(pwr_press & (8'($urandom_range(0, 255)) | 8'h02) & pwr_press,
                       1'($urandom_range(0, 1)), 1'b1);
            random_mix(150, 1'b0, 1'b0);
            case (ending)
                END_SECOND_PRESS: begin
                    send_panel(pwr_press, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    random_mix(150, 1'b1, 1'b1);
                end
                END_PANIC: begin
                    send_fields(MODE_PANIC, 8'h00, 1'b1, 1'b0, 8'hff);
                    send_fields(MODE_PANIC, 8'hff, 1'b0, 1'b1, 8'h00);
                    send_panel(pwr_press, 1'b0, 1'b0);
                    random_mix(150, 1'b1, 1'b1);
                end
                default: random_mix(150, 1'b0, 1'b0);
            endcase
        end
        drain_results();

        // Latched state: registers at extremes, all kinds of items must change nothing
        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        write_reg(IDX_SPARE + 3'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
        random_mix(100, 1'b1, 1'b1);
        drain_results();

        $display("Covered %0d items: %0d panel, %0d tick, %0d panic, %0d volume writes",
                 items_sent, kind_count[MODE_PANEL], kind_count[MODE_TICK],
                 kind_count[MODE_PANIC], kind_count[MODE_VOLUME]);
        $display("%0d results checked over %0d register settings, run ended by %s",
                 checked, settings_used, ending.name());
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
